// ----- rtl/bdir_pkg.sv -----
// Package for the bus device info responder: codes, sizes and the info ROM.
package bdir_pkg;

  localparam int unsigned ReplyWordsDefault = 28;
  localparam int unsigned RomWords = 28;
  localparam int unsigned RomAw = $clog2(RomWords);

  localparam logic [7:0] ReplyOpcode = 8'd5;
  localparam logic [7:0] FrameCmdInfo = 8'd1;
  localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_WR_IGNORED  = 2'd1,
    ST_RD_REJECTED = 2'd2,
    ST_FRAME_DONE  = 2'd3
  } status_e;

  typedef logic [31:0] rom_t [RomWords];

  localparam rom_t InfoRom = '{
    32'h00000001, 32'h000f06fe, 32'h00000000, 32'h00000000,
    32'hff004472, 32'h65616d63, 32'h61737420, 32'h436f6e74,
    32'h726f6c6c, 32'h65722020, 32'h20202020, 32'h20202020,
    32'h50726f64, 32'h75636564, 32'h20427920, 32'h6f722055,
    32'h6e646572, 32'h204c6963, 32'h656e7365, 32'h2046726f,
    32'h6d205345, 32'h47412045, 32'h4e544552, 32'h50524953,
    32'h45532c4c, 32'h54442e20, 32'h20202020, 32'hae01f401
  };

endpackage

// ----- rtl/bus_device_info_responder.sv -----
// Top level of the bus device info responder: frame receive and reply transmit.
//
//  channel   dir  tdata           tuser (low bit up)
//  s_axis    in   write_data[31:0] command
//  m_axis    out  read_data[31:0]  more_words, status[1:0]
//
// One transfer per cycle in each direction while the output is not stalled; each
// input transfer yields one output transfer through the output register.
// The info ROM is read ahead into a register, addressed by the next reply index.
// Input is taken while the output register is empty or being drained.
// Reset clears all frame state and returns the block to receive.
module bus_device_info_responder #(
  parameter int unsigned REPLY_WORDS = bdir_pkg::ReplyWordsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // write_data
  input  logic        s_axis_tuser_i,   // command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // read_data
  output logic [2:0]  m_axis_tuser_o    // more_words, status[1:0]
);

  localparam logic [7:0] ReplyLen = 8'(REPLY_WORDS);
  localparam logic [8:0] ReplyLast = 9'(REPLY_WORDS);

  logic       tx_q, tx_d;
  logic [7:0] idx_q, idx_d;
  logic [7:0] cmd_q, cmd_d;
  logic [7:0] src_q, src_d;
  logic [7:0] dst_q, dst_d;
  logic [7:0] size_q, size_d;
  logic       known_q, known_d;

  logic        out_vld_q;
  logic [31:0] out_data_q, out_data_d;
  logic        out_more_q, out_more_d;
  bdir_pkg::status_e out_st_q, out_st_d;

  logic [31:0] rom_q;
  logic [7:0]  rom_addr;
  logic        rom_hit;

  logic        accept;
  logic [7:0]  idx_inc;
  logic [8:0]  idx_next;
  logic [7:0]  size_eff;

  assign s_axis_tready_o = !out_vld_q || m_axis_tready_i;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    tx_d       = tx_q;
    idx_d      = idx_q;
    cmd_d      = cmd_q;
    src_d      = src_q;
    dst_d      = dst_q;
    size_d     = size_q;
    known_d    = known_q;
    out_data_d = '0;
    out_more_d = 1'b0;
    out_st_d   = bdir_pkg::ST_OK;
    idx_inc    = idx_q + 8'd1;
    idx_next   = {1'b0, idx_q} + 9'd1;
    size_eff   = (idx_q == 8'd0) ? s_axis_tdata_i[31:24] : size_q;
    if (accept) begin
      unique case (bdir_pkg::cmd_e'(s_axis_tuser_i))
        bdir_pkg::CMD_WRITE: begin
          if (tx_q) begin
            out_st_d = bdir_pkg::ST_WR_IGNORED;
          end else begin
            if (idx_q == 8'd0) begin
              cmd_d  = s_axis_tdata_i[7:0];
              src_d  = s_axis_tdata_i[15:8];
              dst_d  = s_axis_tdata_i[23:16];
              size_d = s_axis_tdata_i[31:24];
            end
            idx_d = idx_inc;
            if (idx_inc >= size_eff || idx_inc == 8'd0) begin
              tx_d     = 1'b1;
              idx_d    = 8'd0;
              known_d  = (cmd_d == bdir_pkg::FrameCmdInfo);
              out_st_d = bdir_pkg::ST_FRAME_DONE;
            end
          end
        end
        bdir_pkg::CMD_READ: begin
          if (!tx_q || !known_q) begin
            out_data_d = bdir_pkg::AllOnes;
            out_st_d   = bdir_pkg::ST_RD_REJECTED;
          end else begin
            out_data_d = (idx_q == 8'd0)
                       ? {bdir_pkg::ReplyOpcode, dst_q, src_q | 8'd1, ReplyLen}
                       : rom_q;
            if (idx_next > ReplyLast) begin
              tx_d  = 1'b0;
              idx_d = 8'd0;
            end else begin
              idx_d      = idx_next[7:0];
              out_more_d = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // ROM prefetch: word for the index the next transfer will see
  assign rom_addr = idx_d - 8'd1;
  assign rom_hit  = (idx_d != 8'd0) && (rom_addr < 8'(bdir_pkg::RomWords));

  always_ff @(posedge clk_i) begin
    if (rom_hit) begin
      rom_q <= bdir_pkg::InfoRom[rom_addr[bdir_pkg::RomAw-1:0]];
    end else begin
      rom_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_q      <= 1'b0;
      idx_q     <= '0;
      cmd_q     <= '0;
      src_q     <= '0;
      dst_q     <= '0;
      size_q    <= '0;
      known_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      tx_q    <= tx_d;
      idx_q   <= idx_d;
      cmd_q   <= cmd_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
      size_q  <= size_d;
      known_q <= known_d;
      if (accept) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
      out_more_q <= out_more_d;
      out_st_q   <= out_st_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = {out_st_q, out_more_q};

endmodule

// ----- verif/bus_device_info_responder_tb.sv -----
// Self-checking testbench for the bus device info responder: frames, replies and stuck state.
module bus_device_info_responder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkHalf = 5;
  localparam int unsigned ReplyLen = bdir_pkg::ReplyWordsDefault;
  localparam int unsigned TableWords = 28;
  localparam int unsigned PressureAt = 200;
  localparam int unsigned HoldOffCycles = 300;

  typedef struct packed {
    logic [31:0]       data;
    logic              more;
    bdir_pkg::status_e status;
  } reply_t;

  class reply_checker;
    logic        tx_active;
    logic        info_armed;
    logic [7:0]  word_idx;
    logic [7:0]  frame_cmd;
    logic [7:0]  frame_src;
    logic [7:0]  frame_dst;
    logic [7:0]  frame_size;
    logic [31:0] dev_info [TableWords];
    reply_t      expected_q[$];
    int unsigned n_errors;
    int unsigned n_frames;
    int unsigned n_info_words;
    int unsigned n_ignored;
    int unsigned n_rejected;

    function new();
      tx_active = 1'b0;
      info_armed = 1'b0;
      word_idx = '0;
      frame_cmd = '0;
      frame_src = '0;
      frame_dst = '0;
      frame_size = '0;
      dev_info = '{
        32'h00000001, 32'h000f06fe, 32'h00000000, 32'h00000000,
        32'hff004472, 32'h65616d63, 32'h61737420, 32'h436f6e74,
        32'h726f6c6c, 32'h65722020, 32'h20202020, 32'h20202020,
        32'h50726f64, 32'h75636564, 32'h20427920, 32'h6f722055,
        32'h6e646572, 32'h204c6963, 32'h656e7365, 32'h2046726f,
        32'h6d205345, 32'h47412045, 32'h4e544552, 32'h50524953,
        32'h45532c4c, 32'h54442e20, 32'h20202020, 32'hae01f401
      };
      n_errors = 0;
      n_frames = 0;
      n_info_words = 0;
      n_ignored = 0;
      n_rejected = 0;
    endfunction

    function logic [31:0] info_word(logic [7:0] idx);
      if (idx == 8'd0) begin
        return {bdir_pkg::ReplyOpcode, frame_dst, frame_src | 8'h01, 8'(ReplyLen)};
      end
      if (int'(idx) - 1 < int'(TableWords)) begin
        return dev_info[int'(idx) - 1];
      end
      return '0;
    endfunction

    function void note_access(bdir_pkg::cmd_e cmd, logic [31:0] wdata);
      reply_t exp;
      int     nxt;
      exp.data = '0;
      exp.more = 1'b0;
      exp.status = bdir_pkg::ST_OK;
      if (cmd == bdir_pkg::CMD_WRITE) begin
        if (tx_active) begin
          exp.status = bdir_pkg::ST_WR_IGNORED;
          n_ignored++;
        end else begin
          if (word_idx == 8'd0) begin
            {frame_size, frame_dst, frame_src, frame_cmd} = wdata;
          end
          word_idx = word_idx + 8'd1;
          if (word_idx >= frame_size || word_idx == 8'd0) begin
            tx_active = 1'b1;
            word_idx = '0;
            info_armed = (frame_cmd == bdir_pkg::FrameCmdInfo);
            exp.status = bdir_pkg::ST_FRAME_DONE;
            n_frames++;
          end
        end
      end else if (!tx_active || !info_armed) begin
        exp.data = bdir_pkg::AllOnes;
        exp.status = bdir_pkg::ST_RD_REJECTED;
        n_rejected++;
      end else begin
        exp.data = info_word(word_idx);
        nxt = int'(word_idx) + 1;
        if (nxt > int'(ReplyLen)) begin
          tx_active = 1'b0;
          word_idx = '0;
        end else begin
          word_idx = 8'(nxt);
          exp.more = 1'b1;
        end
        n_info_words++;
      end
      expected_q.push_back(exp);
    endfunction

    function void check_reply(logic [31:0] data, logic [2:0] user);
      reply_t exp;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected transfer data %h user %b", $time, data, user);
        n_errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (data !== exp.data) begin
        $display("%0t: read_data expected %h actual %h", $time, exp.data, data);
        n_errors++;
      end
      if (user[0] !== exp.more) begin
        $display("%0t: more_words expected %b actual %b", $time, exp.more, user[0]);
        n_errors++;
      end
      if (user[2:1] !== exp.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp.status, user[2:1]);
        n_errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  reply_checker replies = new();
  int unsigned  n_sent = 0;
  int unsigned  n_drained = 0;
  bit           send_calm = 1'b0;
  bit           drain_calm = 1'b0;

  bus_device_info_responder i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        replies.note_access(bdir_pkg::cmd_e'(s_axis_tuser), s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        replies.check_reply(m_axis_tdata, m_axis_tuser);
      end
    end
  end

  task automatic send_access(bdir_pkg::cmd_e cmd, logic [31:0] wdata);
    int unsigned gap;
    gap = send_calm ? 0 : $urandom_range(0, 19);
    if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= wdata;
    s_axis_tuser <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
  endtask

  task automatic send_frame(logic [7:0] cmd, logic [7:0] src, logic [7:0] dst,
                            logic [7:0] size);
    send_access(bdir_pkg::CMD_WRITE, {size, dst, src, cmd});
    for (int i = 1; i < int'(size); i++) send_access(bdir_pkg::CMD_WRITE, $urandom());
  endtask

  // full reply: header plus table, stray writes optionally mixed in
  task automatic read_info_reply(bit noisy);
    for (int i = 0; i <= int'(ReplyLen); i++) begin
      if (noisy && $urandom_range(0, 7) == 0) send_access(bdir_pkg::CMD_WRITE, $urandom());
      send_access(bdir_pkg::CMD_READ, $urandom());
    end
  endtask

  // receiver side, with one long hold-off to back the block up
  initial begin
    int unsigned stall;
    wait (rst_ni);
    forever begin
      if (n_drained == PressureAt) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
      end
      stall = drain_calm ? 0 : $urandom_range(0, 19);
      if ($urandom_range(0, 29) == 0) drain_calm = !drain_calm;
      if (stall > 0) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      n_drained++;
    end
  end

  initial begin
    #(5ms);
    $display("bus_device_info_responder_tb failed");
    $finish;
  end

  initial begin
    logic [7:0]  len;
    logic [7:0]  bad_cmd;
    int unsigned pick;
    int unsigned n_long;
    n_long = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_access(bdir_pkg::CMD_READ, 32'hFFFF_FFFF);
    send_frame(bdir_pkg::FrameCmdInfo, 8'hFE, 8'hFF, 8'h00);
    send_access(bdir_pkg::CMD_WRITE, 32'hFFFF_FFFF);
    read_info_reply(1'b0);
    send_access(bdir_pkg::CMD_READ, 32'h0000_0000);

    while (n_sent < 480) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) send_access(bdir_pkg::CMD_READ, $urandom());
      end
      pick = $urandom_range(0, 19);
      if (pick == 0 && n_long < 2 && n_sent < 150) begin
        len = 8'hFF;
        n_long++;
      end else if (pick < 6) begin
        len = 8'($urandom_range(5, 16));
      end else begin
        len = 8'($urandom_range(0, 4));
      end
      send_frame(bdir_pkg::FrameCmdInfo, 8'($urandom()), 8'($urandom()), len);
      read_info_reply($urandom_range(0, 2) == 0);
    end

    // unknown command: block locks up, so this comes last (256 wraps to 0)
    bad_cmd = 8'($urandom_range(2, 256));
    send_frame(bad_cmd, 8'($urandom()), 8'($urandom()), 8'($urandom_range(0, 3)));
    repeat (12) send_access(bdir_pkg::cmd_e'($urandom_range(0, 1)), $urandom());
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (replies.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d transfers in, %0d frames closed, %0d reply words read",
             n_sent, replies.n_frames, replies.n_info_words);
    $display("%0d writes ignored, %0d reads rejected, ending in the locked state",
             replies.n_ignored, replies.n_rejected);
    if (replies.n_errors == 0 && replies.expected_q.size() == 0) begin
      $display("bus_device_info_responder_tb passed");
    end else begin
      $display("bus_device_info_responder_tb failed");
    end
    $finish;
  end

endmodule
